FILE: design/irs_pkg.sv
// Shared types and constants of the inverse roulette selector.
// No dependencies; irs_ctrl, irs_datapath and the top level import this package.
`default_nettype none

package irs_pkg;

  // Store depth and the widths that follow from it
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Field widths
  localparam int CFG_W    = 7;
  localparam int ENTRY_W  = 6;
  localparam int FIT_W    = 32;
  localparam int SPIN_W   = 17;
  localparam int CHOSEN_W = 6;
  localparam int WEIGHT_W = 32;

  localparam int TOTAL_W     = WEIGHT_W + IDX_W;
  localparam int TARGET_W    = TOTAL_W + SPIN_W;
  localparam int SPIN_FRAC_W = 16;

  localparam int CMP_N_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int CMP_E_W = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;

  // Reciprocal divider: quotient bits, one per step
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0]    ACTIVE_RESET  = CFG_W'(64);
  localparam logic [SPIN_W-1:0]   SPIN_ONE      = SPIN_W'(65536);
  localparam logic [FIT_W-1:0]    FIT_SAT_LIMIT = FIT_W'(65536);
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX    = '1;
  // 2^48 shifted right by the quotient width: the first partial remainder
  localparam logic [FIT_W-1:0]    DIV_REM_INIT  = FIT_W'(65536);

  localparam logic ACT_STORE  = 1'b0;
  localparam logic ACT_SELECT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_WRITE,
    ST_SUM,
    ST_SUM_END,
    ST_MUL,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } irs_state_t;

  typedef struct packed {
    logic load;       // capture an accepted item
    logic clr;        // write zero at the walk address, advance
    logic div_step;   // one restoring division step
    logic wr_weight;  // write the weight of a store item
    logic issue;      // read the weight at the walk address, advance
    logic mul;        // form spin * total, start the prefix scan
  } irs_cmd_t;

  typedef struct packed {
    logic sel;        // captured item is a select
    logic idx_ok;     // store entry lies inside the store
    logic sat;        // weight saturates, no division needed
    logic clr_last;   // walk address at the last store entry
    logic walk_last;  // walk address at the last active entry
    logic div_last;   // final division step
  } irs_status_t;

endpackage

`default_nettype wire

FILE: design/irs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module irs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/irs_ctrl.sv
// Controller state machine of the inverse roulette selector.
// Depends on irs_pkg; drives irs_datapath through irs_cmd_t.
`default_nettype none

module irs_ctrl import irs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire irs_status_t status,
  output irs_cmd_t         cmd,
  output logic             busy,
  output logic             out_valid
);

  irs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:     if (start) state_nxt = ST_DECODE;
      ST_DECODE: begin
        if (status.sel) state_nxt = ST_SUM;
        else if (!status.idx_ok) state_nxt = ST_IDLE;
        else if (status.sat) state_nxt = ST_WRITE;
        else state_nxt = ST_DIV;
      end
      ST_DIV:      if (status.div_last) state_nxt = ST_WRITE;
      ST_WRITE:    state_nxt = ST_IDLE;
      ST_SUM:      if (status.walk_last) state_nxt = ST_SUM_END;
      ST_SUM_END:  state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_SCAN;
      ST_SCAN:     if (status.walk_last) state_nxt = ST_SCAN_END;
      ST_SCAN_END: state_nxt = ST_DONE;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    busy          = 1'b1;
    out_valid     = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_WRITE: cmd.wr_weight = 1'b1;
      ST_SUM:   cmd.issue     = 1'b1;
      ST_MUL:   cmd.mul       = 1'b1;
      ST_SCAN:  cmd.issue     = 1'b1;
      ST_DONE:  out_valid     = 1'b1;
      default:  cmd           = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/irs_datapath.sv
// Datapath of the inverse roulette selector: item registers, reciprocal
// divider, weight store walk and prefix compare. Depends on irs_pkg, irs_ram.
`default_nettype none

module irs_datapath import irs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire irs_cmd_t            cmd,
  output irs_status_t              status,
  input  wire logic                cfg_we,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic                in_action,
  input  wire logic [ENTRY_W-1:0]  in_entry_index,
  input  wire logic [FIT_W-1:0]    in_fitness_value,
  input  wire logic [SPIN_W-1:0]   in_spin,
  output logic      [CHOSEN_W-1:0] out_chosen_index
);

  // Control registers
  logic [CFG_W-1:0]     active_r, active_nxt;
  logic [IDX_W-1:0]     addr_r, addr_nxt;
  logic                 pend_r, pend_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 scan_r, scan_nxt;
  logic                 found_r, found_nxt;

  // Payload registers
  logic                 sel_r, sel_nxt;
  logic                 idx_ok_r, idx_ok_nxt;
  logic                 sat_r, sat_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [SPIN_W-1:0]    spin_r, spin_nxt;
  logic [FIT_W-1:0]     div_r, div_nxt;
  logic [FIT_W-1:0]     rem_r, rem_nxt;
  logic [WEIGHT_W-1:0]  q_r, q_nxt;
  logic [IDX_W-1:0]     rd_addr_r, rd_addr_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [TOTAL_W-1:0]   run_r, run_nxt;
  logic [TARGET_W-1:0]  target_r, target_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;

  logic [CMP_N_W-1:0]   act_wide;
  logic [FIT_W:0]       rem_shift;
  logic                 rem_ge;
  logic [TOTAL_W-1:0]   run_sum;
  logic                 hit;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WEIGHT_W-1:0]  ram_wdata;
  logic [WEIGHT_W-1:0]  ram_rdata;

  irs_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign ram_we    = cmd.clr | cmd.wr_weight;
  assign ram_waddr = cmd.clr ? addr_r : idx_r;
  assign ram_wdata = cmd.clr ? '0 : (sat_r ? WEIGHT_MAX : q_r);

  assign act_wide  = CMP_N_W'(active_r);
  assign rem_shift = {rem_r, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, div_r};
  assign run_sum   = run_r + TOTAL_W'(ram_rdata);
  assign hit       = !found_r &&
                     (target_r <= TARGET_W'({run_sum, {SPIN_FRAC_W{1'b0}}}));

  always_comb begin
    active_nxt  = cfg_we ? cfg_data : active_r;
    addr_nxt    = addr_r;
    pend_nxt    = cmd.issue;
    div_cnt_nxt = div_cnt_r;
    scan_nxt    = scan_r;
    found_nxt   = found_r;
    sel_nxt     = sel_r;
    idx_ok_nxt  = idx_ok_r;
    sat_nxt     = sat_r;
    idx_nxt     = idx_r;
    n_nxt       = n_r;
    spin_nxt    = spin_r;
    div_nxt     = div_r;
    rem_nxt     = rem_r;
    q_nxt       = q_r;
    rd_addr_nxt = cmd.issue ? addr_r : rd_addr_r;
    total_nxt   = total_r;
    run_nxt     = run_r;
    target_nxt  = target_r;
    pick_nxt    = pick_r;

    if (cmd.load) begin
      addr_nxt    = '0;
      div_cnt_nxt = '0;
      scan_nxt    = 1'b0;
      sel_nxt     = in_action == ACT_SELECT;
      idx_ok_nxt  = CMP_E_W'(in_entry_index) < CMP_E_W'(MAX_ENTRIES);
      sat_nxt     = in_fitness_value <= FIT_SAT_LIMIT;
      idx_nxt     = IDX_W'(in_entry_index);
      spin_nxt    = (in_spin > SPIN_ONE) ? SPIN_ONE : in_spin;
      div_nxt     = in_fitness_value;
      rem_nxt     = DIV_REM_INIT;
      total_nxt   = '0;
      if (act_wide == '0) begin
        n_nxt = CNT_W'(1);
      end else if (act_wide > CMP_N_W'(MAX_ENTRIES)) begin
        n_nxt = CNT_W'(MAX_ENTRIES);
      end else begin
        n_nxt = CNT_W'(act_wide);
      end
    end

    if (cmd.clr || cmd.issue) begin
      addr_nxt = addr_r + IDX_W'(1);
    end

    if (cmd.div_step) begin
      rem_nxt     = rem_ge ? FIT_W'(rem_shift - {1'b0, div_r}) : rem_shift[FIT_W-1:0];
      q_nxt       = {q_r[WEIGHT_W-2:0], rem_ge};
      div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
    end

    if (cmd.mul) begin
      target_nxt = TARGET_W'(spin_r) * TARGET_W'(total_r);
      addr_nxt   = '0;
      scan_nxt   = 1'b1;
      found_nxt  = 1'b0;
      run_nxt    = '0;
      pick_nxt   = IDX_W'(n_r - CNT_W'(1));
    end

    // Fold in the weight whose read was issued in the cycle before
    if (pend_r) begin
      if (!scan_r) begin
        total_nxt = total_r + TOTAL_W'(ram_rdata);
      end else begin
        run_nxt = run_sum;
        if (hit) begin
          found_nxt = 1'b1;
          pick_nxt  = rd_addr_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= ACTIVE_RESET;
      addr_r    <= '0;
      pend_r    <= 1'b0;
      div_cnt_r <= '0;
      scan_r    <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      addr_r    <= addr_nxt;
      pend_r    <= pend_nxt;
      div_cnt_r <= div_cnt_nxt;
      scan_r    <= scan_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r     <= sel_nxt;
    idx_ok_r  <= idx_ok_nxt;
    sat_r     <= sat_nxt;
    idx_r     <= idx_nxt;
    n_r       <= n_nxt;
    spin_r    <= spin_nxt;
    div_r     <= div_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    rd_addr_r <= rd_addr_nxt;
    total_r   <= total_nxt;
    run_r     <= run_nxt;
    target_r  <= target_nxt;
    pick_r    <= pick_nxt;
  end

  assign status.sel       = sel_r;
  assign status.idx_ok    = idx_ok_r;
  assign status.sat       = sat_r;
  assign status.clr_last  = addr_r == IDX_W'(MAX_ENTRIES - 1);
  assign status.walk_last = addr_r == IDX_W'(n_r - CNT_W'(1));
  assign status.div_last  = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);

  assign out_chosen_index = CHOSEN_W'(pick_r);

endmodule

`default_nettype wire

FILE: design/inverse_roulette_selector.sv
// Inverse-fitness roulette wheel selector: top level.
// Depends on irs_pkg, irs_ctrl, irs_datapath (which holds irs_ram).
//
// Usage:
//   Items enter on start while busy is low. A store item (in_action = 0)
//   turns in_fitness_value (unsigned Q16.16) into the weight
//   floor(2^48 / fitness), saturated to 2^32-1, and writes it to entry
//   in_entry_index; it gives no result. A select item (in_action = 1)
//   picks an entry with probability proportional to its weight, using
//   in_spin (65536 = 1.0), and pulses out_valid for one cycle with
//   out_chosen_index. The receiver cannot stall: sample on out_valid.
//   The active entry count is written on cfg_valid (cfg_ready always high).
// Sequencing (n = active entries):
//   store: the next item is taken after the weight write; a weight that
//   does not saturate first runs a 32-step restoring divider, one quotient bit a cycle.
//   select: the result comes after two walks over the n active entries
//   through the single read port of the weight RAM: one to total the
//   weights, one to scan prefix sums. The next item is taken in the cycle
//   after out_valid.
// Reset: rst_n (synchronous) starts a clearing pass that zeroes all MAX_ENTRIES
//   (64) entries of the weight store, with busy high; config is still taken.

`default_nettype none

module inverse_roulette_selector import irs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // item channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_action,
  input  wire logic [ENTRY_W-1:0]  in_entry_index,
  input  wire logic [FIT_W-1:0]    in_fitness_value,
  input  wire logic [SPIN_W-1:0]   in_spin,
  // result channel
  output logic                     out_valid,
  output logic      [CHOSEN_W-1:0] out_chosen_index,
  // configuration channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_W-1:0]    cfg_active_count
);

  irs_cmd_t    cmd;
  irs_status_t status;

  // User must send config writes only while idle (block does not check); take at once
  assign cfg_ready = 1'b1;

  // Sequence the store/select work
  irs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Hold the weights, divide, sum and scan
  irs_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_data         (cfg_active_count),
    .in_action        (in_action),
    .in_entry_index   (in_entry_index),
    .in_fitness_value (in_fitness_value),
    .in_spin          (in_spin),
    .out_chosen_index (out_chosen_index)
  );

endmodule

`default_nettype wire

FILE: design/irs_checker.sv
// Port-level assertions for inverse_roulette_selector, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none

module irs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // A result only shows up while an item is at work
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("out_valid while not busy");

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // A result frees the block in the next cycle
  a_out_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("block not idle after result");

  // Reset starts the clearing pass
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("not busy after reset");

endmodule

bind inverse_roulette_selector irs_checker u_irs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire
